### src/dtsc_pkg.sv
// Shared types, constants and codes for the dependency order resolver.
package dtsc_pkg;

    localparam int MAX_NODES = 32;
    localparam int IDX_SPAN = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int LIMIT_NODES = (MAX_NODES < IDX_SPAN) ? MAX_NODES : IDX_SPAN;

    localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
    localparam logic [1:0] REQ_RESOLVE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_NONE     = 2'd3;

    localparam logic [1:0] KIND_ORDER   = 2'd0;
    localparam logic [1:0] KIND_CYCLE   = 2'd1;
    localparam logic [1:0] KIND_UNRES   = 2'd2;

    localparam logic [1:0] MARK_NONE    = 2'd0;
    localparam logic [1:0] MARK_OPEN    = 2'd1;
    localparam logic [1:0] MARK_DONE    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SEED,
        ST_DEQ,
        ST_RELAX,
        ST_EMIT_ORDER,
        ST_DFS_ROOT,
        ST_DFS_TOP,
        ST_DFS_SCAN,
        ST_CYC_FIND,
        ST_EMIT_CYC,
        ST_EMIT_UNRES
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] node_index;
        logic [1:0]       result_kind;
        logic             last_item;
    } out_item_t;

endpackage

### src/dependency_topo_sort_cycle_finder_unit.sv
// Top level of the dependency order resolver with its sequencer.
// Requests arrive one at a time. A resolve request recounts in-degrees by sweeping the 32
// matrix rows, seeds the queue and then relaxes each dequeued node by scanning its row one
// neighbour per cycle; the shared index counter drives each of these steps. When all active
// nodes are placed, the N order entries follow, one per cycle while the result side takes
// them. Otherwise a depth-first search walks the graph one edge test per cycle while it
// scans a row, then scans the stack for the start of the cycle and emits its path, or emits
// one unresolved result. No new request is taken until the run has handed its last result
// to the output register. The node count register may be written at any time the block is
// idle; a count of zero acts as one and counts above the node limit saturate.
module dependency_topo_sort_cycle_finder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dtsc_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [dtsc_pkg::IDX_W-1:0]    s_provider_node,
    input  logic [dtsc_pkg::IDX_W-1:0]    s_dependent_node,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dtsc_pkg::IDX_W-1:0]    m_node_index,
    output logic [1:0]                    m_result_kind,
    output logic                          m_last_item
);

    localparam int IW = dtsc_pkg::IDX_W;
    localparam int CW = dtsc_pkg::CNT_W;
    localparam int NS = dtsc_pkg::IDX_SPAN;

    dtsc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] node_count_reg;
    logic [CW-1:0] active_n;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] root_reg, root_next;
    logic [IW-1:0] u_reg, u_next;
    logic [IW-1:0] v_reg, v_next;
    logic [NS-1:0] row_reg, row_next;

    logic [CW-1:0] pending_reg [NS];
    logic [IW-1:0] order_reg [NS];
    logic [1:0]    mark_reg [NS];
    logic [IW-1:0] stk_node_reg [NS];
    logic [CW-1:0] stk_cur_reg [NS];

    logic          in_acc;
    logic          edge_set, edge_clr;
    logic [IW-1:0] edge_rd_addr;
    logic [NS-1:0] edge_rd_row;

    logic [IW-1:0] cur_idx, sp_m1, order_addr, stk_addr, mark_addr;
    logic [IW-1:0] order_rd, stk_node_rd;
    logic [CW-1:0] stk_cur_rd, pend_rd;
    logic [1:0]    mark_rd;

    logic          pend_clr, pend_count, pend_dec;
    logic          order_we;
    logic          mark_clr, mark_we;
    logic [IW-1:0] mark_wa;
    logic [1:0]    mark_wd;
    logic          stk_push, stk_cur_upd;
    logic [IW-1:0] stk_push_a;
    logic [IW-1:0] stk_push_node;

    logic                out_load, out_free;
    dtsc_pkg::out_item_t out_item, m_item;

    // Active node count after saturation.
    always_comb begin
        if (node_count_reg == '0) begin
            active_n = CW'(1);
        end else if (node_count_reg > CW'(dtsc_pkg::LIMIT_NODES)) begin
            active_n = CW'(dtsc_pkg::LIMIT_NODES);
        end else begin
            active_n = node_count_reg;
        end
    end

    assign s_ready  = (state_reg == dtsc_pkg::ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign edge_set = in_acc && (s_req_type == dtsc_pkg::REQ_ADD_EDGE);
    assign edge_clr = in_acc && (s_req_type == dtsc_pkg::REQ_CLEAR);

    // Each small store has one read port, addressed by the index counter or a pointer.
    assign cur_idx    = cur_reg[IW-1:0];
    assign sp_m1      = IW'(sp_reg - CW'(1));
    assign order_addr = (state_reg == dtsc_pkg::ST_EMIT_ORDER) ? cur_idx : head_reg[IW-1:0];
    assign stk_addr   = (state_reg == dtsc_pkg::ST_DFS_TOP) ? sp_m1 : cur_idx;
    assign mark_addr  = (state_reg == dtsc_pkg::ST_DFS_ROOT) ? root_reg[IW-1:0] : cur_idx;

    assign order_rd    = order_reg[order_addr];
    assign stk_node_rd = stk_node_reg[stk_addr];
    assign stk_cur_rd  = stk_cur_reg[stk_addr];
    assign mark_rd     = mark_reg[mark_addr];
    assign pend_rd     = pending_reg[cur_idx];

    always_comb begin
        case (state_reg)
            dtsc_pkg::ST_COUNT:   edge_rd_addr = cur_idx;
            dtsc_pkg::ST_DEQ:     edge_rd_addr = order_rd;
            dtsc_pkg::ST_DFS_TOP: edge_rd_addr = stk_node_rd;
            default:              edge_rd_addr = '0;
        endcase
    end

    dtsc_edge_store u_edges (
        .aclk    (aclk),
        .aresetn (aresetn),
        .set_en  (edge_set),
        .clr_en  (edge_clr),
        .set_row (s_provider_node),
        .set_col (s_dependent_node),
        .rd_addr (edge_rd_addr),
        .rd_row  (edge_rd_row)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dtsc_pkg::ST_IDLE: begin
                if (in_acc && s_req_type == dtsc_pkg::REQ_RESOLVE) begin
                    state_next = dtsc_pkg::ST_COUNT;
                end
            end
            dtsc_pkg::ST_COUNT: begin
                if (cur_reg == CW'(NS - 1)) begin
                    state_next = dtsc_pkg::ST_SEED;
                end
            end
            dtsc_pkg::ST_SEED: begin
                if (cur_reg == active_n) begin
                    state_next = dtsc_pkg::ST_DEQ;
                end
            end
            dtsc_pkg::ST_DEQ: begin
                if (head_reg < tail_reg) begin
                    state_next = dtsc_pkg::ST_RELAX;
                end else if (tail_reg == active_n) begin
                    state_next = dtsc_pkg::ST_EMIT_ORDER;
                end else begin
                    state_next = dtsc_pkg::ST_DFS_ROOT;
                end
            end
            dtsc_pkg::ST_RELAX: begin
                if (cur_reg == active_n) begin
                    state_next = dtsc_pkg::ST_DEQ;
                end
            end
            dtsc_pkg::ST_EMIT_ORDER: begin
                if (out_free && (cur_reg + CW'(1) == active_n)) begin
                    state_next = dtsc_pkg::ST_IDLE;
                end
            end
            dtsc_pkg::ST_DFS_ROOT: begin
                if (root_reg == active_n) begin
                    state_next = dtsc_pkg::ST_EMIT_UNRES;
                end else if (mark_rd == dtsc_pkg::MARK_NONE) begin
                    state_next = dtsc_pkg::ST_DFS_TOP;
                end
            end
            dtsc_pkg::ST_DFS_TOP: begin
                if (sp_reg == '0) begin
                    state_next = dtsc_pkg::ST_DFS_ROOT;
                end else begin
                    state_next = dtsc_pkg::ST_DFS_SCAN;
                end
            end
            dtsc_pkg::ST_DFS_SCAN: begin
                if (cur_reg >= active_n) begin
                    state_next = dtsc_pkg::ST_DFS_TOP;
                end else if (row_reg[cur_idx]) begin
                    if (mark_rd == dtsc_pkg::MARK_OPEN) begin
                        state_next = dtsc_pkg::ST_CYC_FIND;
                    end else begin
                        state_next = dtsc_pkg::ST_DFS_TOP;
                    end
                end
            end
            dtsc_pkg::ST_CYC_FIND: begin
                if (stk_node_rd == v_reg) begin
                    state_next = dtsc_pkg::ST_EMIT_CYC;
                end
            end
            dtsc_pkg::ST_EMIT_CYC: begin
                if (out_free && cur_reg >= sp_reg) begin
                    state_next = dtsc_pkg::ST_IDLE;
                end
            end
            dtsc_pkg::ST_EMIT_UNRES: begin
                if (out_free) begin
                    state_next = dtsc_pkg::ST_IDLE;
                end
            end
            default: state_next = dtsc_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls, counters and result selection.
    always_comb begin
        cur_next      = cur_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        sp_next       = sp_reg;
        root_next     = root_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        row_next      = row_reg;
        pend_clr      = 1'b0;
        pend_count    = 1'b0;
        pend_dec      = 1'b0;
        order_we      = 1'b0;
        mark_clr      = 1'b0;
        mark_we       = 1'b0;
        mark_wa       = cur_idx;
        mark_wd       = dtsc_pkg::MARK_OPEN;
        stk_push      = 1'b0;
        stk_push_a    = sp_reg[IW-1:0];
        stk_push_node = cur_idx;
        stk_cur_upd   = 1'b0;
        out_load      = 1'b0;
        out_item      = '{node_index: '0, result_kind: dtsc_pkg::KIND_ORDER, last_item: 1'b0};
        case (state_reg)
            dtsc_pkg::ST_IDLE: begin
                if (in_acc && s_req_type == dtsc_pkg::REQ_RESOLVE) begin
                    cur_next  = '0;
                    head_next = '0;
                    tail_next = '0;
                    pend_clr  = 1'b1;
                end
            end
            dtsc_pkg::ST_COUNT: begin
                pend_count = 1'b1;
                cur_next   = (cur_reg == CW'(NS - 1)) ? '0 : cur_reg + CW'(1);
            end
            dtsc_pkg::ST_SEED: begin
                if (cur_reg != active_n) begin
                    if (pend_rd == '0) begin
                        order_we  = 1'b1;
                        tail_next = tail_reg + CW'(1);
                    end
                    cur_next = cur_reg + CW'(1);
                end
            end
            dtsc_pkg::ST_DEQ: begin
                cur_next = '0;
                if (head_reg < tail_reg) begin
                    row_next  = edge_rd_row;
                    head_next = head_reg + CW'(1);
                end else if (tail_reg != active_n) begin
                    mark_clr  = 1'b1;
                    root_next = '0;
                end
            end
            dtsc_pkg::ST_RELAX: begin
                if (cur_reg != active_n) begin
                    if (row_reg[cur_idx] && pend_rd != '0) begin
                        pend_dec = 1'b1;
                        if (pend_rd == CW'(1)) begin
                            order_we  = 1'b1;
                            tail_next = tail_reg + CW'(1);
                        end
                    end
                    cur_next = cur_reg + CW'(1);
                end
            end
            dtsc_pkg::ST_EMIT_ORDER: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_item = '{node_index: order_rd, result_kind: dtsc_pkg::KIND_ORDER,
                                 last_item: (cur_reg + CW'(1) == active_n)};
                    cur_next = cur_reg + CW'(1);
                end
            end
            dtsc_pkg::ST_DFS_ROOT: begin
                if (root_reg != active_n) begin
                    if (mark_rd != dtsc_pkg::MARK_NONE) begin
                        root_next = root_reg + CW'(1);
                    end else begin
                        mark_we       = 1'b1;
                        mark_wa       = root_reg[IW-1:0];
                        stk_push      = 1'b1;
                        stk_push_a    = '0;
                        stk_push_node = root_reg[IW-1:0];
                        sp_next       = CW'(1);
                    end
                end
            end
            dtsc_pkg::ST_DFS_TOP: begin
                if (sp_reg == '0) begin
                    root_next = root_reg + CW'(1);
                end else begin
                    u_next   = stk_node_rd;
                    cur_next = stk_cur_rd;
                    row_next = edge_rd_row;
                end
            end
            dtsc_pkg::ST_DFS_SCAN: begin
                if (cur_reg >= active_n) begin
                    mark_we = 1'b1;
                    mark_wa = u_reg;
                    mark_wd = dtsc_pkg::MARK_DONE;
                    sp_next = sp_reg - CW'(1);
                end else if (!row_reg[cur_idx]) begin
                    cur_next = cur_reg + CW'(1);
                end else begin
                    stk_cur_upd = 1'b1;
                    if (mark_rd == dtsc_pkg::MARK_OPEN) begin
                        v_next   = cur_idx;
                        cur_next = '0;
                    end else if (mark_rd == dtsc_pkg::MARK_NONE && sp_reg < CW'(NS)) begin
                        mark_we  = 1'b1;
                        stk_push = 1'b1;
                        sp_next  = sp_reg + CW'(1);
                    end
                end
            end
            dtsc_pkg::ST_CYC_FIND: begin
                if (stk_node_rd != v_reg) begin
                    cur_next = cur_reg + CW'(1);
                end
            end
            dtsc_pkg::ST_EMIT_CYC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (cur_reg < sp_reg) begin
                        out_item = '{node_index: stk_node_rd,
                                     result_kind: dtsc_pkg::KIND_CYCLE, last_item: 1'b0};
                        cur_next = cur_reg + CW'(1);
                    end else begin
                        out_item = '{node_index: v_reg,
                                     result_kind: dtsc_pkg::KIND_CYCLE, last_item: 1'b1};
                    end
                end
            end
            dtsc_pkg::ST_EMIT_UNRES: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_item = '{node_index: '0, result_kind: dtsc_pkg::KIND_UNRES,
                                 last_item: 1'b1};
                end
            end
            default: begin
                cur_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dtsc_pkg::ST_IDLE;
            node_count_reg <= CW'(32);
            cur_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            sp_reg         <= '0;
            root_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            cur_reg  <= cur_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            sp_reg   <= sp_next;
            root_reg <= root_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        row_reg <= row_next;
    end

    // In-degree counters: all lanes count in parallel during the row sweep.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (!aresetn || pend_clr) begin
                pending_reg[k] <= '0;
            end else if (pend_count) begin
                pending_reg[k] <= pending_reg[k] + CW'(edge_rd_row[k]);
            end else if (pend_dec && cur_idx == IW'(k)) begin
                pending_reg[k] <= pending_reg[k] - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_reg[tail_reg[IW-1:0]] <= cur_idx;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (!aresetn || mark_clr) begin
                mark_reg[k] <= dtsc_pkg::MARK_NONE;
            end else if (mark_we && mark_wa == IW'(k)) begin
                mark_reg[k] <= mark_wd;
            end
        end
    end

    // The cursor of the top frame and a new frame may be written in the same cycle.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (stk_push && stk_push_a == IW'(k)) begin
                stk_node_reg[k] <= stk_push_node;
                stk_cur_reg[k]  <= '0;
            end else if (stk_cur_upd && sp_m1 == IW'(k)) begin
                stk_cur_reg[k]  <= cur_reg + CW'(1);
            end
        end
    end

    dtsc_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (out_load),
        .item    (out_item),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_node_index  = m_item.node_index;
    assign m_result_kind = m_item.result_kind;
    assign m_last_item   = m_item.last_item;

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over a waiting result");

    // The queue never grows beyond the active node count while placing nodes.
    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dtsc_pkg::ST_RELAX || state_reg == dtsc_pkg::ST_DEQ)
        |-> (tail_reg <= active_n && head_reg <= tail_reg))
        else $error("queue pointers out of range");

    // The search only scans a row while a frame is on the stack.
    a_scan_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dtsc_pkg::ST_DFS_SCAN) |-> (sp_reg != '0 && sp_reg <= CW'(NS)))
        else $error("search stack empty or overflowed during scan");

endmodule

### src/dtsc_edge_store.sv
// Adjacency bit matrix with single-bit set, bulk clear and one row read port.
module dtsc_edge_store (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 set_en,
    input  logic                                 clr_en,
    input  logic [dtsc_pkg::IDX_W-1:0]           set_row,
    input  logic [dtsc_pkg::IDX_W-1:0]           set_col,
    input  logic [dtsc_pkg::IDX_W-1:0]           rd_addr,
    output logic [dtsc_pkg::IDX_SPAN-1:0]        rd_row
);

    logic [dtsc_pkg::IDX_SPAN-1:0] row_reg [dtsc_pkg::IDX_SPAN];

    always_ff @(posedge aclk) begin
        if (!aresetn || clr_en) begin
            for (int k = 0; k < dtsc_pkg::IDX_SPAN; k++) begin
                row_reg[k] <= '0;
            end
        end else if (set_en) begin
            row_reg[set_row][set_col] <= 1'b1;
        end
    end

    assign rd_row = row_reg[rd_addr];

endmodule

### src/dtsc_out_reg.sv
// Output register that holds one result until the downstream side takes it.
module dtsc_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  dtsc_pkg::out_item_t  item,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dtsc_pkg::out_item_t  m_item
);

    logic                valid_reg;
    logic                valid_next;
    dtsc_pkg::out_item_t item_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

### bench/dependency_topo_sort_cycle_finder_unit_tb.sv
// Self-checking bench for the dependency order resolver: directed and random requests.
module dependency_topo_sort_cycle_finder_unit_tb;

    // One request as the sender presents it.
    typedef struct packed {
        logic [1:0]                 req_type;
        logic [dtsc_pkg::IDX_W-1:0] provider;
        logic [dtsc_pkg::IDX_W-1:0] dependent;
    } request_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [dtsc_pkg::CNT_W-1:0]   cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [1:0]                   s_req_type;
    logic [dtsc_pkg::IDX_W-1:0]   s_provider_node;
    logic [dtsc_pkg::IDX_W-1:0]   s_dependent_node;
    logic                         m_valid;
    logic                         m_ready;
    logic [dtsc_pkg::IDX_W-1:0]   m_node_index;
    logic [1:0]                   m_result_kind;
    logic                         m_last_item;

    dependency_topo_sort_cycle_finder_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_provider_node  (s_provider_node),
        .s_dependent_node (s_dependent_node),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_node_index     (m_node_index),
        .m_result_kind    (m_result_kind),
        .m_last_item      (m_last_item)
    );

    // Mirror of the block's state, kept by the predictor.
    logic [31:0]                graph_rows [32];
    logic [dtsc_pkg::CNT_W-1:0] count_reg;

    request_t             pending_requests [$];
    dtsc_pkg::out_item_t  awaited_results  [$];

    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  sender_paused;
    bit  receiver_hold;
    int  hold_cycles;
    int  mismatch_count;
    int  result_count;
    int  request_count;
    int  resolve_count;
    int  resolve_mark;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Appends one expected result to the queue.
    task automatic expect_result(input dtsc_pkg::out_item_t item);
        awaited_results = {awaited_results, item};
    endtask

    // Appends one request to the queue of pending requests.
    task automatic queue_request(input request_t req);
        pending_requests = {pending_requests, req};
    endtask

    // Appends the expected results of a resolve request to the queue.
    task automatic predict_resolve();
        int        n;
        int        indeg [32];
        logic [4:0] placed [32];
        int        head;
        int        tail;
        int        u;
        int        mark [32];
        int        stk_node [32];
        int        stk_cur [32];
        int        sp;
        int        v;
        int        start;
        dtsc_pkg::out_item_t item;
        n = (count_reg == 0) ? 1 : ((count_reg > dtsc_pkg::LIMIT_NODES) ?
                                    dtsc_pkg::LIMIT_NODES : count_reg);
        for (int d = 0; d < n; d++) begin
            indeg[d] = 0;
            for (int p = 0; p < 32; p++) indeg[d] += graph_rows[p][d];
        end
        head = 0;
        tail = 0;
        for (int d = 0; d < n; d++) begin
            if (indeg[d] == 0) begin
                placed[tail] = d[4:0];
                tail++;
            end
        end
        while (head < tail) begin
            u = placed[head];
            head++;
            for (int d = 0; d < n; d++) begin
                if (graph_rows[u][d] && indeg[d] != 0) begin
                    indeg[d]--;
                    if (indeg[d] == 0) begin
                        placed[tail] = d[4:0];
                        tail++;
                    end
                end
            end
        end
        if (tail == n) begin
            for (int k = 0; k < n; k++) begin
                item.node_index  = placed[k];
                item.result_kind = dtsc_pkg::KIND_ORDER;
                item.last_item   = (k == n - 1);
                expect_result(item);
            end
            return;
        end
        // Not all nodes placed: search for a cycle in index order.
        for (int k = 0; k < 32; k++) mark[k] = dtsc_pkg::MARK_NONE;
        for (int r = 0; r < n; r++) begin
            if (mark[r] != dtsc_pkg::MARK_NONE) continue;
            mark[r] = dtsc_pkg::MARK_OPEN;
            stk_node[0] = r;
            stk_cur[0] = 0;
            sp = 1;
            while (sp > 0) begin
                u = stk_node[sp-1];
                v = stk_cur[sp-1];
                while (v < n && !graph_rows[u][v]) v++;
                if (v >= n) begin
                    mark[u] = dtsc_pkg::MARK_DONE;
                    sp--;
                    continue;
                end
                stk_cur[sp-1] = v + 1;
                if (mark[v] == dtsc_pkg::MARK_OPEN) begin
                    start = 0;
                    for (int k = 0; k < sp; k++) begin
                        if (stk_node[k] == v) begin
                            start = k;
                            break;
                        end
                    end
                    for (int k = start; k < sp; k++) begin
                        item.node_index  = stk_node[k][4:0];
                        item.result_kind = dtsc_pkg::KIND_CYCLE;
                        item.last_item   = 1'b0;
                        expect_result(item);
                    end
                    item.node_index  = v[4:0];
                    item.result_kind = dtsc_pkg::KIND_CYCLE;
                    item.last_item   = 1'b1;
                    expect_result(item);
                    return;
                end
                if (mark[v] == dtsc_pkg::MARK_NONE && sp < 32) begin
                    mark[v] = dtsc_pkg::MARK_OPEN;
                    stk_node[sp] = v;
                    stk_cur[sp] = 0;
                    sp++;
                end
            end
        end
        item.node_index  = '0;
        item.result_kind = dtsc_pkg::KIND_UNRES;
        item.last_item   = 1'b1;
        expect_result(item);
    endtask

    // Applies one accepted request to the mirrored state.
    task automatic predict_request(input request_t req);
        case (req.req_type)
            dtsc_pkg::REQ_ADD_EDGE: begin
                graph_rows[req.provider][req.dependent] = 1'b1;
            end
            dtsc_pkg::REQ_RESOLVE: begin
                predict_resolve();
                resolve_count++;
            end
            dtsc_pkg::REQ_CLEAR: begin
                for (int k = 0; k < 32; k++) graph_rows[k] = '0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic request_t make_req(input logic [1:0] kind, input int p, input int d);
        request_t r;
        r.req_type  = kind;
        r.provider  = p[4:0];
        r.dependent = d[4:0];
        return r;
    endfunction

    // Driver: offers the head of the pending queue; valid stays up until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_request({s_req_type, s_provider_node, s_dependent_node});
                request_count++;
            end
            if (!s_valid || s_ready) begin
                if (s_valid && s_ready) void'(pending_requests.pop_front());
                if (pending_requests.size() > 0 && !sender_paused &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    s_valid          <= 1'b1;
                    s_req_type       <= pending_requests[0].req_type;
                    s_provider_node  <= pending_requests[0].provider;
                    s_dependent_node <= pending_requests[0].dependent;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        dtsc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: node %0d kind %0d last %0b",
                             m_node_index, m_result_kind, m_last_item);
            end else begin
                want = awaited_results.pop_front();
                if (want.node_index !== m_node_index || want.result_kind !== m_result_kind ||
                    want.last_item !== m_last_item) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected node %0d kind %0d last %0b, got %0d %0d %0b",
                                 want.node_index, want.result_kind, want.last_item,
                                 m_node_index, m_result_kind, m_last_item);
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Long receiver hold-off, counted in cycles in its own process.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            receiver_hold <= 1'b1;
        end else begin
            receiver_hold <= 1'b0;
        end
    end

    // Waits for the queue of requests to drain and every expected result to arrive.
    task automatic drain();
        wait (pending_requests.size() == 0 && !s_valid);
        wait (awaited_results.size() == 0);
        // A trailing add or clear is applied when accepted; the bench still waits after it.
        repeat (1200) @(posedge aclk);
    endtask

    task automatic set_count(input int value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[dtsc_pkg::CNT_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        count_reg = value[dtsc_pkg::CNT_W-1:0];
    endtask

    // Clear, a random graph (mostly forward edges, sometimes a back edge), then a resolve.
    task automatic queue_random_graph(input int span, input int edges);
        int p;
        int d;
        queue_request(make_req(dtsc_pkg::REQ_CLEAR, $urandom, $urandom));
        for (int k = 0; k < edges; k++) begin
            p = $urandom_range(span - 1);
            d = $urandom_range(span - 1);
            if ($urandom_range(9) < 7 && p > d) begin
                p = p ^ d; d = p ^ d; p = p ^ d;
            end
            if ($urandom_range(19) == 0) begin
                p = $urandom_range(31);
                d = $urandom_range(31);
            end
            queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, p, d));
        end
        if ($urandom_range(9) == 0)
            queue_request(make_req(dtsc_pkg::REQ_NONE, $urandom, $urandom));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, $urandom, $urandom));
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_req_type       = '0;
        s_provider_node  = '0;
        s_dependent_node = '0;
        m_ready          = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        sender_paused    = 1'b0;
        receiver_hold    = 1'b0;
        hold_cycles      = 0;
        mismatch_count   = 0;
        result_count     = 0;
        request_count    = 0;
        resolve_count    = 0;
        resolve_mark     = 0;
        count_reg        = 6'd32;
        for (int k = 0; k < 32; k++) graph_rows[k] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at full count: empty graph, then a chain on the extreme nodes.
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 31, 0));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 31, 0));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 0, 21));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 10, 31));
        queue_request(make_req(dtsc_pkg::REQ_NONE, 31, 31));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 31, 31));
        // Closing a loop, then a self edge on its own.
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 21, 10));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        queue_request(make_req(dtsc_pkg::REQ_CLEAR, 0, 0));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 5, 5));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        drain();

        // Small count: edges from an inactive provider leave a node unplaced without a cycle,
        // and edges into inactive nodes are ignored.
        set_count(4);
        queue_request(make_req(dtsc_pkg::REQ_CLEAR, 0, 0));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 3, 30));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 1, 2));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        queue_request(make_req(dtsc_pkg::REQ_ADD_EDGE, 20, 1));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        drain();
        // A count of zero acts as one; above the limit saturates.
        set_count(0);
        queue_request(make_req(dtsc_pkg::REQ_CLEAR, 0, 0));
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        drain();
        set_count(63);
        queue_request(make_req(dtsc_pkg::REQ_RESOLVE, 0, 0));
        drain();

        // Random phases with differing idling and node counts.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
            endcase
            set_count((phase == 0) ? 32 : ((phase == 1) ? 1 : $urandom_range(2, 12)));
            for (int g = 0; g < 3; g++) queue_random_graph((phase == 0) ? 32 : 12, 6);
            if (phase == 2) begin
                // Stall the result side long enough for the input to back up.
                hold_cycles = 400;
            end
            drain();
        end

        // Once a resolve has been taken, the sender pauses until all its results are in.
        resolve_mark = resolve_count;
        queue_random_graph(6, 4);
        queue_random_graph(6, 4);
        wait (resolve_count > resolve_mark);
        sender_paused = 1'b1;
        wait (awaited_results.size() == 0);
        repeat (20) @(posedge aclk);
        sender_paused = 1'b0;
        drain();

        $display("summary: %0d requests, %0d resolve runs, %0d results checked",
                 request_count, resolve_count, result_count);
        $display("covered node counts 0, 1, 4, 32, 63 and random, with idling and stalls");
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

### dependency_topo_sort_cycle_finder_unit.f
src/dtsc_pkg.sv
src/dtsc_edge_store.sv
src/dtsc_out_reg.sv
src/dependency_topo_sort_cycle_finder_unit.sv
bench/dependency_topo_sort_cycle_finder_unit_tb.sv
